>>> design/lrrc_pkg.sv
// Package with item types, constants and the CRC-32 byte update for the log record checker.
package lrrc_pkg;

	// One input item: an operation code and a log byte.
	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
	} in_item_t;

	// One result item, given at the end of a log.
	typedef struct packed {
		logic [31:0] record_count;
		logic [39:0] torn_offset;
		logic        was_torn;
	} out_item_t;

	// Operation codes.
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_END  = 1'b1;

	// Scan phase codes; the unused code behaves like the torn phase.
	localparam logic [1:0] PHASE_HEADER  = 2'd0;
	localparam logic [1:0] PHASE_PAYLOAD = 2'd1;
	localparam logic [1:0] PHASE_TORN    = 2'd2;

	localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
	localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;
	localparam logic [31:0] DEFAULT_MAX_LEN = 32'd1048576;
	localparam logic [3:0]  HEADER_BYTES    = 4'd8;
	localparam logic [2:0]  LAST_HDR_INDEX  = 3'd7;

	// Reflected CRC-32 update over one byte, least significant bit first.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

endpackage

>>> design/log_record_replay_checker_top.sv
// Top level of the length-prefixed CRC-32 log record checker.
// Throughput: one item per cycle, but an end-of-log item waits while the result register is full and stalled;
// byte items are taken even while a result waits. The result of an end-of-log item is valid in the cycle after
// it is taken. The header parse and the bytewise CRC update are combinational logic on the scan state.
// An end-of-log item is stalled only while the result register is full and stalled.
// Reset (arst_n low, asynchronous) clears the scan state and sets the maximum length to 1048576.
module log_record_replay_checker_top
	import lrrc_pkg::*;
#(
	parameter int OFFSET_WIDTH = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;

	logic [31:0]             max_len_q;
	logic [1:0]              phase_q;
	logic [2:0]              hdr_idx_q;
	logic [31:0]             rec_len_q;
	logic [31:0]             exp_crc_q;
	logic [31:0]             run_crc_q;
	logic [31:0]             remain_q;
	logic [OFFSET_WIDTH-1:0] start_off_q;
	logic [31:0]             good_q;

	logic                    accept;
	logic                    out_free;

	// Next-state values of the scan.
	logic [1:0]              phase_d;
	logic [2:0]              hdr_idx_d;
	logic [31:0]             rec_len_d;
	logic [31:0]             exp_crc_d;
	logic [31:0]             run_crc_d;
	logic [31:0]             remain_d;
	logic [OFFSET_WIDTH-1:0] start_off_d;
	logic [31:0]             good_d;

	logic                    finish;
	logic [31:0]             fin_crc;
	logic [32:0]             rec_size;
	logic [OFFSET_WIDTH:0]   off_sum;

	// Always writable; the user must change configuration only while idle (the block does not check).
	assign cfg_ready = 1'b1;

	// Only an end-of-log item needs room in the result register.
	assign out_free = !out_valid || !out_stall;
	assign in_stall = (in_item.operation == OP_END) && !out_free;
	assign accept   = in_valid && !in_stall;

	// Record size and saturating advance of the record start offset.
	assign rec_size = {1'b0, rec_len_d} + {29'd0, HEADER_BYTES};
	assign off_sum  = {1'b0, start_off_q} + (OFFSET_WIDTH + 1)'(rec_size);

	// Scan logic for one log byte.
	always_comb begin
		phase_d     = phase_q;
		hdr_idx_d   = hdr_idx_q;
		rec_len_d   = rec_len_q;
		exp_crc_d   = exp_crc_q;
		run_crc_d   = run_crc_q;
		remain_d    = remain_q;
		start_off_d = start_off_q;
		good_d      = good_q;
		finish      = 1'b0;
		fin_crc     = run_crc_q;
		unique case (phase_q)
			PHASE_HEADER: begin
				if (!hdr_idx_q[2]) begin
					rec_len_d = {rec_len_q[23:0], in_item.data_byte};
				end else begin
					exp_crc_d = {exp_crc_q[23:0], in_item.data_byte};
				end
				hdr_idx_d = hdr_idx_q + 3'd1;
				if (hdr_idx_q == LAST_HDR_INDEX) begin
					run_crc_d = CRC_INIT;
					remain_d  = rec_len_d;
					fin_crc   = CRC_INIT;
					if (rec_len_d > max_len_q) begin
						phase_d = PHASE_TORN;
					end else if (rec_len_d == 32'd0) begin
						finish = 1'b1;
					end else begin
						phase_d = PHASE_PAYLOAD;
					end
				end
			end
			PHASE_PAYLOAD: begin
				run_crc_d = crc_byte(run_crc_q, in_item.data_byte);
				remain_d  = remain_q - 32'd1;
				fin_crc   = run_crc_d;
				if (remain_d == 32'd0) begin
					finish = 1'b1;
				end
			end
			default: begin
			end
		endcase
		// Judge a finished record: count it and move past it, or mark the log torn.
		if (finish) begin
			if (~fin_crc != exp_crc_d) begin
				phase_d = PHASE_TORN;
			end else begin
				if (good_q != COUNT_MAX) begin
					good_d = good_q + 32'd1;
				end
				start_off_d = off_sum[OFFSET_WIDTH] ? OFFSET_MAX : off_sum[OFFSET_WIDTH-1:0];
				phase_d     = PHASE_HEADER;
				hdr_idx_d   = 3'd0;
			end
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= DEFAULT_MAX_LEN;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	// Scan state: advance on a byte item, clear on an end-of-log item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PHASE_HEADER;
			hdr_idx_q   <= 3'd0;
			rec_len_q   <= 32'd0;
			exp_crc_q   <= 32'd0;
			run_crc_q   <= CRC_INIT;
			remain_q    <= 32'd0;
			start_off_q <= '0;
			good_q      <= 32'd0;
		end else if (accept) begin
			if (in_item.operation == OP_END) begin
				phase_q     <= PHASE_HEADER;
				hdr_idx_q   <= 3'd0;
				rec_len_q   <= 32'd0;
				exp_crc_q   <= 32'd0;
				run_crc_q   <= CRC_INIT;
				remain_q    <= 32'd0;
				start_off_q <= '0;
				good_q      <= 32'd0;
			end else begin
				phase_q     <= phase_d;
				hdr_idx_q   <= hdr_idx_d;
				rec_len_q   <= rec_len_d;
				exp_crc_q   <= exp_crc_d;
				run_crc_q   <= run_crc_d;
				remain_q    <= remain_d;
				start_off_q <= start_off_d;
				good_q      <= good_d;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept && (in_item.operation == OP_END)) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Result register payload, loaded by an end-of-log item.
	always_ff @(posedge clk) begin
		if (accept && (in_item.operation == OP_END)) begin
			out_item.record_count <= good_q;
			out_item.torn_offset  <= 40'(start_off_q);
			out_item.was_torn     <= !((phase_q == PHASE_HEADER) && (hdr_idx_q == 3'd0));
		end
	end

endmodule

>>> bench/log_record_replay_checker_top_test.sv
// Self-checking testbench for the length-prefixed CRC-32 log record checker.
module log_record_replay_checker_top_test
	import lrrc_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT       = 4000;
	localparam int DRAIN_CYCLES      = 4;
	localparam int SEGMENT_COUNT     = 6;
	localparam int SEGMENT_ITEMS     = 320;
	localparam int SHORT_PAYLOAD_MAX = 24;
	localparam int LONG_PAYLOAD_MAX  = 400;
	localparam logic [31:0] LEN_ALL_ONES = 32'hFFFF_FFFF;

	// Tracks the scan state of the log checker and holds the end-of-log reports it owes.
	class log_scoreboard;
		logic [31:0] max_len;
		logic [1:0]  phase;
		logic [2:0]  hdr_idx;
		logic [31:0] rec_len;
		logic [31:0] stored_crc;
		logic [31:0] crc_acc;
		logic [31:0] bytes_left;
		logic [39:0] rec_start;
		logic [31:0] good_count;
		out_item_t   pending_reports[$];
		int          errors;
		int          reports_checked;
		int          torn_reports;

		function new();
			max_len = DEFAULT_MAX_LEN;
			errors = 0;
			reports_checked = 0;
			torn_reports = 0;
			clear_scan();
		endfunction

		// Reflected CRC-32, one data bit at a time, least significant bit first.
		static function logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
			logic fb;
			for (int i = 0; i < 8; i++) begin
				fb = c[0] ^ b[i];
				c = c >> 1;
				if (fb) begin
					c = c ^ CRC_POLY;
				end
			end
			return c;
		endfunction

		function void clear_scan();
			phase = PHASE_HEADER;
			hdr_idx = '0;
			rec_len = '0;
			stored_crc = '0;
			crc_acc = CRC_INIT;
			bytes_left = '0;
			rec_start = '0;
			good_count = '0;
		endfunction

		// A record is complete: count it and move past it, or mark the log torn.
		function void close_record();
			logic [40:0] next_start;
			if (~crc_acc != stored_crc) begin
				phase = PHASE_TORN;
				return;
			end
			if (good_count != COUNT_MAX) begin
				good_count = good_count + 1;
			end
			next_start = {1'b0, rec_start} + 41'(HEADER_BYTES) + 41'(rec_len);
			rec_start = next_start[40] ? '1 : next_start[39:0];
			phase = PHASE_HEADER;
			hdr_idx = '0;
		endfunction

		// Advance the scan state by one accepted item.
		function void note_item(in_item_t it);
			out_item_t rep;
			if (it.operation == OP_BYTE) begin
				if (phase == PHASE_HEADER) begin
					// Length bytes come first, then the stored CRC, both big-endian.
					if (hdr_idx[2] == 1'b0) begin
						rec_len = {rec_len[23:0], it.data_byte};
					end else begin
						stored_crc = {stored_crc[23:0], it.data_byte};
					end
					if (hdr_idx == LAST_HDR_INDEX) begin
						hdr_idx = '0;
						crc_acc = CRC_INIT;
						bytes_left = rec_len;
						if (rec_len > max_len) begin
							phase = PHASE_TORN;
						end else if (rec_len == 0) begin
							close_record();
						end else begin
							phase = PHASE_PAYLOAD;
						end
					end else begin
						hdr_idx = hdr_idx + 3'd1;
					end
				end else if (phase == PHASE_PAYLOAD) begin
					crc_acc = crc_update(crc_acc, it.data_byte);
					bytes_left = bytes_left - 1;
					if (bytes_left == 0) begin
						close_record();
					end
				end
			end else begin
				rep.record_count = good_count;
				rep.torn_offset = rec_start;
				rep.was_torn = !(phase == PHASE_HEADER && hdr_idx == 0);
				pending_reports.push_back(rep);
				clear_scan();
			end
		endfunction

		// Compare one accepted report with the oldest one owed.
		function void check_report(out_item_t got);
			out_item_t want;
			if (pending_reports.size() == 0) begin
				$error("report with none owed: record_count %0d torn_offset %0d was_torn %0d",
					got.record_count, got.torn_offset, got.was_torn);
				errors++;
				return;
			end
			want = pending_reports.pop_front();
			if (got.record_count !== want.record_count) begin
				$error("record_count: expected %0d, actual %0d", want.record_count,
					got.record_count);
				errors++;
			end
			if (got.torn_offset !== want.torn_offset) begin
				$error("torn_offset: expected %0d, actual %0d", want.torn_offset,
					got.torn_offset);
				errors++;
			end
			if (got.was_torn !== want.was_torn) begin
				$error("was_torn: expected %0d, actual %0d", want.was_torn, got.was_torn);
				errors++;
			end
			reports_checked++;
			if (want.was_torn) begin
				torn_reports++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	log_scoreboard board = new();
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int items_sent = 0;
	int logs_sent = 0;
	int quiet_cycles = 0;

	log_record_replay_checker_top #(
		.OFFSET_WIDTH(40)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Random back-pressure on the report side.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_stall_pct);
	end

	// Handshakes are sampled at the falling edge, where every signal has settled.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				board.note_item(in_item);
			end
			if (out_valid && !out_stall) begin
				board.check_report(out_item);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("Verification failed");
					$finish;
				end
			end
		end
	end

	// Present one item, with a random gap first, and hold it until it is taken.
	task automatic send_item(input logic op, input logic [7:0] b);
		logic stalled;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{operation: op, data_byte: b};
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		items_sent++;
	endtask

	task automatic send_noise(input int count);
		for (int i = 0; i < count; i++) begin
			send_item(OP_BYTE, 8'($urandom));
		end
	endtask

	task automatic send_header(input logic [31:0] len, input logic [31:0] crc);
		for (int i = 3; i >= 0; i--) begin
			send_item(OP_BYTE, len[8*i +: 8]);
		end
		for (int i = 3; i >= 0; i--) begin
			send_item(OP_BYTE, crc[8*i +: 8]);
		end
	endtask

	// A complete record with random payload; a corrupted one carries a wrong CRC.
	task automatic send_record(input int len, input bit corrupt);
		logic [7:0]  payload[$];
		logic [7:0]  b;
		logic [31:0] crc;
		logic [31:0] flip;
		crc = CRC_INIT;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			payload.push_back(b);
			crc = log_scoreboard::crc_update(crc, b);
		end
		crc = ~crc;
		if (corrupt) begin
			flip = $urandom;
			if (flip == 0) begin
				flip = 32'd1;
			end
			crc = crc ^ flip;
		end
		send_header(32'(len), crc);
		foreach (payload[i]) begin
			send_item(OP_BYTE, payload[i]);
		end
	endtask

	task automatic end_log();
		send_item(OP_END, 8'($urandom));
		logs_sent++;
	endtask

	// Drop valid, wait for every owed report, then let the pipeline drain.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (board.pending_reports.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [31:0] value);
		logic ready;
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do begin
			@(negedge clk);
			ready = cfg_ready;
			@(posedge clk);
		end while (!ready);
		cfg_valid <= 1'b0;
		board.max_len = value;
	endtask

	// One log: mostly good records, some damaged ones and noise, sometimes a cut-off tail.
	task automatic random_log();
		int          n_rec;
		int          kind;
		int          cap;
		int          len;
		logic [31:0] over;
		cap = (board.max_len < SHORT_PAYLOAD_MAX) ? int'(board.max_len) : SHORT_PAYLOAD_MAX;
		n_rec = $urandom_range(0, 5);
		for (int r = 0; r < n_rec; r++) begin
			kind = $urandom_range(99);
			if (kind < 76) begin
				send_record($urandom_range(0, cap), 1'b0);
			end else if (kind < 84) begin
				send_record($urandom_range(0, cap), 1'b1);
			end else if (kind < 90) begin
				// Length over the limit; with no limit, a huge length swallows the rest.
				if (board.max_len != LEN_ALL_ONES) begin
					over = board.max_len + 32'd1;
					if ($urandom_range(1) == 1 && over < 32'hF000_0000) begin
						over = over + $urandom_range(0, 32'h0FFF_FFFF);
					end
				end else begin
					over = $urandom;
				end
				send_header(over, $urandom);
				send_noise($urandom_range(0, 4));
			end else if (kind < 95) begin
				send_noise($urandom_range(1, 12));
			end else begin
				if (board.max_len >= 64) begin
					len = $urandom_range(64, (board.max_len < LONG_PAYLOAD_MAX) ?
						int'(board.max_len) : LONG_PAYLOAD_MAX);
				end else begin
					len = cap;
				end
				send_record(len, 1'b0);
			end
		end
		// Cut-off tail: inside a header, or inside a payload.
		if ($urandom_range(7) == 0) begin
			if ($urandom_range(1) == 1 || cap == 0) begin
				send_noise($urandom_range(1, 7));
			end else begin
				len = $urandom_range(1, cap);
				send_header(32'(len), $urandom);
				send_noise($urandom_range(0, len - 1));
			end
		end
		end_log();
	endtask

	function automatic logic [31:0] limit_for(input int seg);
		case (seg)
			0: begin
				return LEN_ALL_ONES;
			end
			1: begin
				return 32'd0;
			end
			2: begin
				return $urandom_range(1, 30);
			end
			3: begin
				return DEFAULT_MAX_LEN;
			end
			4: begin
				return $urandom_range(300, 5000);
			end
			default: begin
				return LEN_ALL_ONES - 1;
			end
		endcase
	endfunction

	initial begin
		int goal;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed logs at the reset limit: empty log, empty record with zero CRC,
		// oversize length, and a log that ends inside a header.
		tx_idle_pct = 18;
		rx_stall_pct = 55;
		end_log();
		send_header(32'd0, 32'd0);
		end_log();
		send_header(DEFAULT_MAX_LEN + 32'd1, $urandom);
		end_log();
		send_noise(3);
		end_log();

		// Random logs under several length limits and idle profiles.
		for (int seg = 0; seg < SEGMENT_COUNT; seg++) begin
			if (seg < 2) begin
				tx_idle_pct = 18;
				rx_stall_pct = 55;
			end else if (seg < 4) begin
				tx_idle_pct = 55;
				rx_stall_pct = 18;
			end else begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
			wait_idle();
			write_limit(limit_for(seg));
			goal = items_sent + SEGMENT_ITEMS;
			while (items_sent < goal) begin
				random_log();
			end
		end
		wait_idle();

		$display("Run covered %0d items in %0d logs under six length limits, 0 and all ones",
			items_sent, logs_sent);
		$display("among them; %0d end-of-log reports checked, %0d of them torn.",
			board.reports_checked, board.torn_reports);
		if (board.errors == 0 && board.pending_reports.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> files.f
design/lrrc_pkg.sv
design/log_record_replay_checker_top.sv
bench/log_record_replay_checker_top_test.sv
